/* src/iee_pkg.sv */
`default_nettype none
package iee_pkg;

  localparam int DEF_STACK_DEPTH = 32;

  localparam logic [2:0] OP_PAREN = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_MOD   = 3'd5;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic digit;
    logic end_num;
    logic push_op;
    logic pop_op;
    logic rd_op;
    logic rd_b;
    logic rd_a;
    logic cap_b;
    logic cap_a;
    logic alu_start;
    logic wb;
    logic rd_top;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic last;
    logic nc_ge2;
    logic nc_nz;
    logic opc_nz;
    logic top_is_paren;
    logic top_prec_ge;
    logic alu_done;
    logic out_busy;
  } stat_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    if (op == OP_MUL || op == OP_DIV || op == OP_MOD) p = 2'd2;
    return p;
  endfunction

endpackage
`default_nettype wire

/* src/iee_ram.sv */
`default_nettype none
module iee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/iee_alu.sv */
`default_nettype none
module iee_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  op,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result,
  output logic             div0
);
  import iee_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

  astate_t     st;
  logic [6:0]  cnt;
  logic [63:0] opa, opb, acc, prod;
  logic [63:0] rem, quo, dvs;
  logic        neg_q, neg_r, is_mod;
  logic [31:0] mx, my;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic [63:0] ua, ub;

  always_comb begin
    mx = (cnt == 7'd2) ? opa[63:32] : opa[31:0];
    my = (cnt == 7'd1) ? opb[63:32] : opb[31:0];
    rem_sh = {rem, quo[63]};
    diff = rem_sh - {1'b0, dvs};
    ua = a[63] ? (64'd0 - a) : a;
    ub = b[63] ? (64'd0 - b) : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      unique case (st)
        A_IDLE: begin
          if (start) begin
            div0 <= 1'b0;
            cnt  <= '0;
            priority if (op == OP_ADD) begin
              result <= a + b;
              done   <= 1'b1;
            end else if (op == OP_SUB) begin
              result <= a - b;
              done   <= 1'b1;
            end else if (op == OP_MUL) begin
              opa <= a;
              opb <= b;
              st  <= A_MUL;
            end else if (op == OP_DIV || op == OP_MOD) begin
              if (b == 64'd0) begin
                result <= 64'd0;
                div0   <= 1'b1;
                done   <= 1'b1;
              end else begin
                rem    <= 64'd0;
                quo    <= ua;
                dvs    <= ub;
                neg_q  <= a[63] ^ b[63];
                neg_r  <= a[63];
                is_mod <= (op == OP_MOD);
                st     <= A_DIV;
              end
            end else begin
              result <= 64'd0;
              done   <= 1'b1;
            end
          end
        end
        A_MUL: begin
          prod <= {32'd0, mx} * {32'd0, my};
          cnt  <= cnt + 7'd1;
          priority case (cnt)
            7'd1: acc <= prod;
            7'd2: acc <= acc + {prod[31:0], 32'd0};
            7'd3: begin
              result <= acc + {prod[31:0], 32'd0};
              done   <= 1'b1;
              st     <= A_IDLE;
            end
            default: ;
          endcase
        end
        A_DIV: begin
          if (cnt == 7'd64) begin
            if (is_mod) result <= neg_r ? (64'd0 - rem) : rem;
            else        result <= neg_q ? (64'd0 - quo) : quo;
            done <= 1'b1;
            st   <= A_IDLE;
          end else begin
            cnt <= cnt + 7'd1;
            if (!diff[64]) begin
              rem <= diff[63:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh[63:0];
              quo <= {quo[62:0], 1'b0};
            end
          end
        end
        default: st <= A_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/iee_dp.sv */
`default_nettype none
module iee_dp #(
  parameter int STACK_DEPTH = iee_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iee_pkg::in_word_t  char_word,
  input  wire iee_pkg::cmd_t      cmd,
  output iee_pkg::stat_t          stat,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output iee_pkg::out_word_t      result_word
);
  import iee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [7:0]    ch;
  logic          last;
  logic [CW-1:0] nc, opc;
  logic [63:0]   acc;
  logic          in_number;
  logic [1:0]    err, err_next;
  logic [63:0]   b_reg, a_reg;
  logic [2:0]    cur_op;
  cls_t          cls;

  logic          num_we, num_re, op_we, op_re;
  logic [AW-1:0] num_waddr, num_raddr;
  logic [63:0]   num_wdata, num_rdata;
  logic [2:0]    op_wdata, op_rdata;
  logic          alu_done, alu_div0;
  logic [63:0]   alu_result;
  logic [CW-1:0] nc_m1, nc_m2, opc_m1;
  logic          num_push_ok, op_push_ok;

  always_comb begin
    cur_op = OP_PAREN;
    if (ch >= CH_ZERO && ch <= CH_NINE) cls = CLS_DIGIT;
    else if (ch == CH_LPAREN) cls = CLS_LPAREN;
    else if (ch == CH_RPAREN) cls = CLS_RPAREN;
    else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
             ch == CH_SLASH || ch == CH_PCT) cls = CLS_OP;
    else cls = CLS_OTHER;
    if (ch == CH_PLUS)  cur_op = OP_ADD;
    if (ch == CH_MINUS) cur_op = OP_SUB;
    if (ch == CH_STAR)  cur_op = OP_MUL;
    if (ch == CH_SLASH) cur_op = OP_DIV;
    if (ch == CH_PCT)   cur_op = OP_MOD;
  end

  assign nc_m1  = nc - CW'(1);
  assign nc_m2  = nc - CW'(2);
  assign opc_m1 = opc - CW'(1);
  assign num_push_ok = (nc < FULL);
  assign op_push_ok  = (opc < FULL);

  always_comb begin
    num_we    = 1'b0;
    num_waddr = nc[AW-1:0];
    num_wdata = acc;
    if (cmd.end_num && in_number && num_push_ok) num_we = 1'b1;
    if (cmd.wb) begin
      num_we    = 1'b1;
      num_waddr = nc_m2[AW-1:0];
      num_wdata = alu_result;
    end
    num_re    = cmd.rd_b || cmd.rd_a || cmd.rd_top;
    num_raddr = cmd.rd_a ? nc_m2[AW-1:0] : nc_m1[AW-1:0];
    op_we     = cmd.push_op && op_push_ok;
    op_wdata  = (cls == CLS_LPAREN) ? OP_PAREN : cur_op;
    op_re     = cmd.rd_op;
  end

  always_comb begin
    err_next = err;
    if (err == ST_OK) begin
      if ((cmd.end_num && in_number && !num_push_ok) ||
          (cmd.push_op && !op_push_ok)) err_next = ST_OVERFLOW;
      if (cmd.wb && alu_div0) err_next = ST_DIV_ZERO;
    end
  end

  iee_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_num_ram (
    .clk(clk), .we(num_we), .waddr(num_waddr), .wdata(num_wdata),
    .re(num_re), .raddr(num_raddr), .rdata(num_rdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk(clk), .we(op_we), .waddr(opc[AW-1:0]), .wdata(op_wdata),
    .re(op_re), .raddr(opc_m1[AW-1:0]), .rdata(op_rdata)
  );

  iee_alu u_alu (
    .clk(clk), .rst(rst), .start(cmd.alu_start), .op(op_rdata),
    .a(a_reg), .b(b_reg), .done(alu_done), .result(alu_result), .div0(alu_div0)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch   <= char_word.char_code;
      last <= char_word.end_of_expression;
    end
    if (cmd.cap_b) b_reg <= num_rdata;
    if (cmd.cap_a) a_reg <= num_rdata;
    if (cmd.out_load) begin
      result_word.value  <= (nc != '0) ? num_rdata : 64'sd0;
      result_word.status <= (err != ST_OK) ? err : ((nc == '0) ? ST_EMPTY : ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nc           <= '0;
      opc          <= '0;
      acc          <= '0;
      in_number    <= 1'b0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      err <= err_next;
      if (cmd.digit) begin
        acc       <= (acc << 3) + (acc << 1) + {56'd0, ch - CH_ZERO};
        in_number <= 1'b1;
      end
      if (cmd.end_num) begin
        acc       <= '0;
        in_number <= 1'b0;
        if (in_number && num_push_ok) nc <= nc + CW'(1);
      end
      if (cmd.wb) begin
        nc  <= nc_m1;
        opc <= opc_m1;
      end
      if (cmd.push_op && op_push_ok) opc <= opc + CW'(1);
      if (cmd.pop_op) opc <= opc_m1;
      if (cmd.clear) begin
        nc        <= '0;
        opc       <= '0;
        acc       <= '0;
        in_number <= 1'b0;
        err       <= ST_OK;
      end
      if (cmd.out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.cls          = cls;
    stat.last         = last;
    stat.nc_ge2       = (nc >= CW'(2));
    stat.nc_nz        = (nc != '0);
    stat.opc_nz       = (opc != '0);
    stat.top_is_paren = (op_rdata == OP_PAREN);
    stat.top_prec_ge  = (prec(op_rdata) >= prec(cur_op));
    stat.alu_done     = alu_done;
    stat.out_busy     = result_valid && !result_ready;
  end
endmodule
`default_nettype wire

/* src/iee_ctrl.sv */
`default_nettype none
module iee_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           char_valid,
  output logic                char_ready,
  input  wire iee_pkg::stat_t stat,
  output iee_pkg::cmd_t       cmd
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FIN_END, S_OPRD, S_OPCHK, S_RDB, S_RDA, S_CAPA,
    S_EXEC, S_WAIT, S_WB, S_LOOPEND, S_PRD, S_PCHK, S_TOPRD, S_OUTLD
  } state_t;

  typedef enum logic [1:0] {M_PREC, M_ALL, M_FINAL} mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  assign char_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IDLE: begin
        if (char_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.cls == CLS_DIGIT) begin
          cmd.digit  = 1'b1;
          state_next = stat.last ? S_FIN_END : S_IDLE;
        end else begin
          cmd.end_num = 1'b1;
          unique case (stat.cls)
            CLS_LPAREN: begin
              cmd.push_op = 1'b1;
              state_next  = stat.last ? S_FIN_END : S_IDLE;
            end
            CLS_OP: begin
              mode_next  = M_PREC;
              state_next = S_OPRD;
            end
            CLS_RPAREN: begin
              mode_next  = M_ALL;
              state_next = S_OPRD;
            end
            default: state_next = stat.last ? S_FIN_END : S_IDLE;
          endcase
        end
      end
      S_FIN_END: begin
        cmd.end_num = 1'b1;
        mode_next   = M_FINAL;
        state_next  = S_OPRD;
      end
      S_OPRD: begin
        if (stat.nc_ge2 && stat.opc_nz) begin
          cmd.rd_op  = 1'b1;
          state_next = S_OPCHK;
        end else begin
          state_next = S_LOOPEND;
        end
      end
      S_OPCHK: begin
        if (!stat.top_is_paren && (mode != M_PREC || stat.top_prec_ge))
          state_next = S_RDB;
        else
          state_next = S_LOOPEND;
      end
      S_RDB: begin
        cmd.rd_b   = 1'b1;
        state_next = S_RDA;
      end
      S_RDA: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_a   = 1'b1;
        state_next = S_CAPA;
      end
      S_CAPA: begin
        cmd.cap_a  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.alu_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.alu_done) state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_OPRD;
      end
      S_LOOPEND: begin
        unique case (mode)
          M_PREC: begin
            cmd.push_op = 1'b1;
            state_next  = stat.last ? S_FIN_END : S_IDLE;
          end
          M_ALL:   state_next = S_PRD;
          default: state_next = S_TOPRD;
        endcase
      end
      S_PRD: begin
        if (stat.opc_nz) begin
          cmd.rd_op  = 1'b1;
          state_next = S_PCHK;
        end else begin
          state_next = stat.last ? S_FIN_END : S_IDLE;
        end
      end
      S_PCHK: begin
        if (stat.top_is_paren) cmd.pop_op = 1'b1;
        state_next = stat.last ? S_FIN_END : S_IDLE;
      end
      S_TOPRD: begin
        cmd.rd_top = 1'b1;
        state_next = S_OUTLD;
      end
      S_OUTLD: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_PREC;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end
endmodule
`default_nettype wire

/* src/infix_expression_evaluator.sv */
// Infix integer expression evaluator.
// char channel: one character word per transfer (char_valid/char_ready),
// end_of_expression marks the last character of an expression.
// result channel: one word (value, status) per expression, held in an
// output register until result_ready; the next characters are taken
// while it waits, and a later result waits only if the register is full.
// A digit or a plain separator is latched and then dispatched.
// An operator or ')' adds a stack check per operator it looks at plus, for
// each reduction, reads of both operands, the arithmetic and a write-back;
// * takes four steps on one 32x32 multiplier, / and % a radix-2 divider.
// The end of an expression adds a final step, the final reductions and
// the load of the result. Stacks sit in single-port-read RAMs; a new
// character is taken only once the previous one is fully processed.
// Reset (rst, synchronous) empties both stacks and clears the error and
// the output valid flag; stack contents need no clearing pass.
`default_nettype none
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::DEF_STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               char_valid,
  output logic                    char_ready,
  input  wire iee_pkg::in_word_t  char_word,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output iee_pkg::out_word_t      result_word
);
  import iee_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iee_ctrl u_ctrl (
    .clk(clk), .rst(rst), .char_valid(char_valid), .char_ready(char_ready),
    .stat(stat), .cmd(cmd)
  );

  iee_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .char_word(char_word), .cmd(cmd), .stat(stat),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_word(result_word)
  );
endmodule
`default_nettype wire
